// ===== rtl/core/edge_notify_backoff_logger_defines.svh =====
// -----------------------------------------------------------------------------
// Edge notify backoff logger assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef EDGE_NOTIFY_BACKOFF_LOGGER_DEFINES_SVH
`define EDGE_NOTIFY_BACKOFF_LOGGER_DEFINES_SVH

// Same-cycle implication
`define ENBL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ENBL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/enbl_pkg.sv =====
// -----------------------------------------------------------------------------
// Edge notify backoff logger package
// Field widths, register and report codes, FSM type and window helper.
// -----------------------------------------------------------------------------
package enbl_pkg;

	localparam int TIME_W      = 32;
	localparam int CNT_W       = 16;
	localparam int SECS_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int DRAIN_W     = 3;

	localparam int LOG_DEPTH_DEF = 8;

	localparam logic [SECS_W-1:0]  MIN_BACKOFF_S = 16'd30;
	localparam logic [TIME_W-1:0]  MS_PER_S      = 32'd1000;
	localparam logic [TIME_W-1:0]  DEBOUNCE_MS   = 32'd1000;
	localparam logic [TIME_W-1:0]  WRAP_LIMIT    = 32'd65536000;
	localparam logic [DRAIN_W-1:0] MAX_DRAIN     = 3'd7;
	localparam logic [CNT_W-1:0]   CNT_MAX       = 16'hFFFF;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED         = 2'd0,
		CFG_RISING_EDGE     = 2'd1,
		CFG_BACKOFF_SECONDS = 2'd2
	} enbl_cfg_idx_t;

	// report kinds
	localparam logic RPT_STATUS = 1'b0;
	localparam logic RPT_ENTRY  = 1'b1;

	// tick sequencer
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_READ = 4'b0100,
		S_WAIT = 4'b1000
	} enbl_state_t;

	// window length in ms, seconds clamped to the minimum
	function automatic logic [TIME_W-1:0] window_ms(input logic [SECS_W-1:0] secs);
		logic [SECS_W-1:0] sc;
		sc = (secs < MIN_BACKOFF_S) ? MIN_BACKOFF_S : secs;
		return TIME_W'(sc) * MS_PER_S;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== rtl/core/enbl_stream_if.sv =====
// -----------------------------------------------------------------------------
// Edge notify backoff logger stream interfaces
// Valid/ready channels for input ticks and for report beats.
// -----------------------------------------------------------------------------
interface enbl_tick_if
	import enbl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] time_ms;
	logic              pin_level;

	modport source (output valid, output time_ms, output pin_level, input ready);
	modport sink   (input valid, input time_ms, input pin_level, output ready);
endinterface

interface enbl_report_if
	import enbl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              report_type;
	logic              push_request;
	logic              led_state;
	logic              backoff_ended;
	logic [CNT_W-1:0]  suppressed_count;
	logic [CNT_W-1:0]  overrun_total;
	logic [TIME_W-1:0] log_time;
	logic              last;

	modport source (
		output valid, output report_type, output push_request, output led_state,
		output backoff_ended, output suppressed_count, output overrun_total,
		output log_time, output last, input ready
	);
	modport sink (
		input valid, input report_type, input push_request, input led_state,
		input backoff_ended, input suppressed_count, input overrun_total,
		input log_time, input last, output ready
	);
endinterface

// ===== rtl/core/edge_notify_backoff_logger.sv =====
// -----------------------------------------------------------------------------
// Edge notify backoff logger
// Pin edge notification with backoff window, debounce count and event log.
// -----------------------------------------------------------------------------
// Each tick beat is captured in the idle state and evaluated in S_EVAL once
// the output register is free. When the window closes, the status beat is
// followed by up to 7 logged timestamps, oldest first; each of them passes
// through S_READ for the registered read of the log memory and S_WAIT to
// load the output register, which waits while the report sink holds ready
// low. A new tick is accepted while the last report beat still waits in the
// output register. Configuration is written through cfg_we/cfg_index/cfg_data.
// -----------------------------------------------------------------------------
`include "edge_notify_backoff_logger_defines.svh"

module edge_notify_backoff_logger
	import enbl_pkg::*;
#(
	parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	enbl_tick_if.sink             tick,
	enbl_report_if.source         report,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(LOG_DEPTH);
	localparam int CW = IW + 1;
	localparam int XW = (CW > DRAIN_W) ? CW : DRAIN_W;

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
		return (x == IW'(LOG_DEPTH - 1)) ? '0 : x + 1'b1;
	endfunction

	// configuration
	logic              en_q;
	logic              rise_q;
	logic [TIME_W-1:0] win_q;

	// tick state
	logic              prev_q, primed_q, active_q, wp_q;
	logic [TIME_W-1:0] wet_q, last_edge_q;
	logic [CNT_W-1:0]  supp_q, ovr_q;
	logic [IW-1:0]     wr_q, rd_q;

	// sequencer
	enbl_state_t        state_q;
	logic [TIME_W-1:0]  t_q;
	logic               pin_q;
	logic [IW-1:0]      drain_ptr_q;
	logic [DRAIN_W-1:0] drain_left_q;

	// log memory
	logic [TIME_W-1:0] log_mem [LOG_DEPTH];
	logic [TIME_W-1:0] rd_data_q;

	// output register
	logic              rep_valid_q;
	logic              rep_type_q, rep_push_q, rep_led_q, rep_ended_q, rep_last_q;
	logic [CNT_W-1:0]  rep_supp_q, rep_ovr_q;
	logic [TIME_W-1:0] rep_time_q;

	// evaluation terms
	logic              slot_free, eval_go;
	logic              edge_hit, open_win, supp_hit, wrap_fix, log_we, full;
	logic [TIME_W:0]   end_sum;
	logic [TIME_W-1:0] deb_lim, wet1;
	logic              wp1, wp2, act_or, ended, act_n;
	logic [CNT_W-1:0]  supp_n, ovr1;
	logic [IW-1:0]     wr_inc, wr1, rd1;
	logic [CW-1:0]     cnt;
	logic [XW-1:0]     cnt_x;
	logic [DRAIN_W-1:0] drain_n;

	assign slot_free = !rep_valid_q || report.ready;
	assign eval_go   = (state_q == S_EVAL) && slot_free;
	assign tick.ready = (state_q == S_IDLE);

	// edge detection, window and debounce
	always_comb begin
		edge_hit = en_q && primed_q &&
			(rise_q ? (pin_q && !prev_q) : (!pin_q && prev_q));
		open_win = edge_hit && !active_q;
		end_sum  = {1'b0, t_q} + {1'b0, win_q};
		deb_lim  = last_edge_q + DEBOUNCE_MS;
		supp_hit = edge_hit && active_q && (t_q > deb_lim);
		wrap_fix = en_q && primed_q && !edge_hit && (t_q < win_q) && (wet_q > WRAP_LIMIT);
		log_we   = open_win || supp_hit;

		wp1    = wp_q || (open_win && end_sum[TIME_W]);
		wp2    = wp1 && !(t_q <= win_q);
		wet1   = open_win ? end_sum[TIME_W-1:0] : (wrap_fix ? '0 : wet_q);
		act_or = active_q || open_win;
		ended  = act_or && !wp2 && (t_q >= wet1);
		act_n  = act_or && !ended;

		if (open_win) begin
			supp_n = '0;
		end else if (supp_hit) begin
			supp_n = sat_inc(supp_q);
		end else begin
			supp_n = supp_q;
		end
	end

	// ring indexes after this tick's write
	always_comb begin
		wr_inc = idx_inc(wr_q);
		full   = log_we && (wr_inc == rd_q);
		wr1    = log_we ? wr_inc : wr_q;
		rd1    = full ? idx_inc(rd_q) : rd_q;
		ovr1   = full ? sat_inc(ovr_q) : ovr_q;
		cnt    = {1'b0, wr1} - {1'b0, rd1} + ((wr1 < rd1) ? CW'(LOG_DEPTH) : '0);
		cnt_x  = XW'(cnt);
		drain_n = (cnt_x > XW'(MAX_DRAIN)) ? MAX_DRAIN : DRAIN_W'(cnt_x);
	end

	// state, configuration and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q         <= 1'b0;
			rise_q       <= 1'b1;
			win_q        <= window_ms(MIN_BACKOFF_S);
			prev_q       <= 1'b0;
			primed_q     <= 1'b0;
			active_q     <= 1'b0;
			wp_q         <= 1'b0;
			wet_q        <= '0;
			last_edge_q  <= '0;
			supp_q       <= '0;
			ovr_q        <= '0;
			wr_q         <= '0;
			rd_q         <= '0;
			state_q      <= S_IDLE;
			drain_ptr_q  <= '0;
			drain_left_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (tick.valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (slot_free) begin
						if (en_q) begin
							primed_q <= 1'b1;
							prev_q   <= pin_q;
						end
						if (edge_hit) begin
							last_edge_q <= t_q;
						end
						wp_q     <= wp2;
						wet_q    <= wet1;
						active_q <= act_n;
						supp_q   <= supp_n;
						if (ended) begin
							wr_q  <= '0;
							rd_q  <= '0;
							ovr_q <= '0;
						end else begin
							wr_q  <= wr1;
							rd_q  <= rd1;
							ovr_q <= ovr1;
						end
						if (ended && (drain_n != '0)) begin
							drain_left_q <= drain_n;
							drain_ptr_q  <= rd1;
							state_q      <= S_READ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_READ: begin
					drain_ptr_q <= idx_inc(drain_ptr_q);
					state_q     <= S_WAIT;
				end
				S_WAIT: begin
					if (slot_free) begin
						drain_left_q <= drain_left_q - 1'b1;
						state_q      <= (drain_left_q == DRAIN_W'(1)) ? S_IDLE : S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// register writes must arrive only while idle; the block itself does not enforce this
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLED: begin
						en_q     <= cfg_data[0];
						active_q <= 1'b0;
						wp_q     <= 1'b0;
						primed_q <= 1'b0;
					end
					CFG_RISING_EDGE: begin
						rise_q <= cfg_data[0];
					end
					CFG_BACKOFF_SECONDS: begin
						win_q <= window_ms(SECS_W'(cfg_data));
					end
					default: begin
					end
				endcase
			end
		end
	end

	// tick capture
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			t_q   <= tick.time_ms;
			pin_q <= tick.pin_level;
		end
	end

	// log memory: write on evaluation, registered read while draining
	always_ff @(posedge clk) begin
		if (eval_go && log_we) begin
			log_mem[wr_q] <= t_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_data_q <= log_mem[drain_ptr_q];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid_q <= 1'b0;
		end else if (eval_go || ((state_q == S_WAIT) && slot_free)) begin
			rep_valid_q <= 1'b1;
		end else if (report.ready) begin
			rep_valid_q <= 1'b0;
		end
	end

	// output register payload: status beat, then entry beats
	always_ff @(posedge clk) begin
		if (eval_go) begin
			rep_type_q  <= RPT_STATUS;
			rep_push_q  <= open_win;
			rep_led_q   <= act_n;
			rep_ended_q <= ended;
			rep_supp_q  <= supp_n;
			rep_ovr_q   <= ovr1;
			rep_time_q  <= '0;
			rep_last_q  <= !(ended && (drain_n != '0));
		end else if ((state_q == S_WAIT) && slot_free) begin
			rep_type_q <= RPT_ENTRY;
			rep_push_q <= 1'b0;
			rep_time_q <= rd_data_q;
			rep_last_q <= (drain_left_q == DRAIN_W'(1));
		end
	end

	assign report.valid            = rep_valid_q;
	assign report.report_type      = rep_type_q;
	assign report.push_request     = rep_push_q;
	assign report.led_state        = rep_led_q;
	assign report.backoff_ended    = rep_ended_q;
	assign report.suppressed_count = rep_supp_q;
	assign report.overrun_total    = rep_ovr_q;
	assign report.log_time         = rep_time_q;
	assign report.last             = rep_last_q;

	// checks
	`ENBL_ASSERT_NEXT(a_accept_eval, tick.valid && tick.ready, state_q == S_EVAL, "accepted tick not evaluated")
	`ENBL_ASSERT_NOW(a_idle_no_drain, tick.ready, drain_left_q == '0, "tick accepted with drain pending")
	`ENBL_ASSERT_NEXT(a_purge, eval_go && ended, (wr_q == '0) && (rd_q == '0) && (ovr_q == '0), "log not purged at window end")
	`ENBL_ASSERT_NOW(a_entry_fields, rep_valid_q && (rep_type_q == RPT_ENTRY), rep_ended_q && !rep_led_q && !rep_push_q, "entry beat outside a window close")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Edge notify backoff logger testbench
// Sends millisecond ticks with pin samples and checks every report beat
// (status and drained log timestamps) against a cycle-free model of the
// backoff window, debounce counter and overwriting event log.
// ----------------------------------------------------------------------------
module tb_top
	import enbl_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LOG_SLOTS   = LOG_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic              pin;
	} tick_item_t;

	typedef struct packed {
		logic              kind;
		logic              push;
		logic              led;
		logic              ended;
		logic [CNT_W-1:0]  supp;
		logic [CNT_W-1:0]  ovr;
		logic [TIME_W-1:0] stamp;
		logic              last;
	} report_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	enbl_tick_if   tick_ch ();
	enbl_report_if rep_ch ();

	edge_notify_backoff_logger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.report    (rep_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// stimulus and scoreboard storage
	tick_item_t   ticks_pending[$];
	report_beat_t reports_due[$];
	int           ticks_issued = 0;
	int           ticks_taken  = 0;
	int           errors       = 0;
	int           gap_left     = 0;
	int           stall_left   = 0;
	bit           calm         = 1'b0;
	logic [TIME_W-1:0] now_ms  = '0;
	logic              pin_now = 1'b0;

	// model copy of the registers
	logic             cfg_en   = 1'b0;
	logic             cfg_rise = 1'b1;
	logic [SECS_W-1:0] cfg_secs = 16'd30;

	// model copy of the block state
	logic              pin_prev    = 1'b0;
	logic              armed       = 1'b0;
	logic              in_backoff  = 1'b0;
	logic              end_wrapped = 1'b0;
	logic [TIME_W-1:0] close_at    = '0;
	logic [TIME_W-1:0] last_hit    = '0;
	logic [CNT_W-1:0]  supp_cnt    = '0;
	logic [CNT_W-1:0]  lost_cnt    = '0;
	logic [TIME_W-1:0] stamps[LOG_SLOTS];
	int                wr_ptr      = 0;
	int                rd_ptr      = 0;

	// ring write; a full ring drops its oldest stamp
	function automatic void log_stamp(input logic [TIME_W-1:0] t);
		stamps[wr_ptr] = t;
		wr_ptr = (wr_ptr + 1) % LOG_SLOTS;
		if (wr_ptr == rd_ptr) begin
			lost_cnt = (lost_cnt == CNT_MAX) ? lost_cnt : lost_cnt + 1'b1;
			rd_ptr = (rd_ptr + 1) % LOG_SLOTS;
		end
	endfunction

	// expected report beats for one accepted tick
	function automatic void compute_reports(input logic [TIME_W-1:0] t, input logic pin);
		logic [TIME_W-1:0] win;
		logic [TIME_W-1:0] close_t;
		logic [TIME_W-1:0] debounce_t;
		logic [SECS_W-1:0] secs_eff;
		logic              hit;
		logic              push;
		logic              ended;
		int                backlog;
		int                n_out;
		report_beat_t      b;

		secs_eff = (cfg_secs < MIN_BACKOFF_S) ? MIN_BACKOFF_S : cfg_secs;
		win = {16'd0, secs_eff} * MS_PER_S;
		push = 1'b0;
		ended = 1'b0;

		if (cfg_en) begin
			if (!armed) begin
				// first sample only sets the reference level
				armed = 1'b1;
			end else begin
				hit = cfg_rise ? (pin && !pin_prev) : (!pin && pin_prev);
				if (hit) begin
					if (!in_backoff) begin
						close_t = t + win;
						push = 1'b1;
						if (close_t < t)
							end_wrapped = 1'b1;
						close_at = close_t;
						supp_cnt = '0;
						in_backoff = 1'b1;
						log_stamp(t);
					end else begin
						debounce_t = last_hit + DEBOUNCE_MS;
						if (t > debounce_t) begin
							supp_cnt = (supp_cnt == CNT_MAX) ? supp_cnt : supp_cnt + 1'b1;
							log_stamp(t);
						end
					end
					last_hit = t;
				end else if (t < win && close_at > WRAP_LIMIT) begin
					close_at = '0;
				end
			end
			pin_prev = pin;
		end

		// wrapped window end waits for the clock to wrap too
		if (end_wrapped && t <= win)
			end_wrapped = 1'b0;
		if (in_backoff && !end_wrapped && t >= close_at) begin
			in_backoff = 1'b0;
			ended = 1'b1;
		end

		backlog = (wr_ptr - rd_ptr + LOG_SLOTS) % LOG_SLOTS;
		n_out = 0;
		if (ended)
			n_out = (backlog > int'(MAX_DRAIN)) ? int'(MAX_DRAIN) : backlog;

		b.kind  = RPT_STATUS;
		b.push  = push;
		b.led   = in_backoff;
		b.ended = ended;
		b.supp  = supp_cnt;
		b.ovr   = lost_cnt;
		b.stamp = '0;
		b.last  = (n_out == 0);
		reports_due.push_back(b);

		// drained stamps, oldest first
		for (int k = 1; k <= n_out; k++) begin
			b.kind  = RPT_ENTRY;
			b.push  = 1'b0;
			b.stamp = stamps[rd_ptr];
			b.last  = (k == n_out);
			rd_ptr = (rd_ptr + 1) % LOG_SLOTS;
			reports_due.push_back(b);
		end

		if (ended) begin
			wr_ptr = 0;
			rd_ptr = 0;
			lost_cnt = '0;
		end
	endfunction

	task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
			input logic [TIME_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	task automatic add_tick(input logic [TIME_W-1:0] t, input logic pin);
		tick_item_t ti;
		ti.stamp = t;
		ti.pin = pin;
		ticks_pending.push_back(ti);
		ticks_issued++;
	endtask

	// random walk of time: short steps for debounce and log fill, long
	// steps to close windows, jumps anywhere and next to the 32-bit wrap
	task automatic add_random_ticks(input int count, input int unsigned span);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				now_ms = now_ms + $urandom_range(0, 1200);
			else if (r < 75)
				now_ms = now_ms + $urandom_range(1001, 3000);
			else if (r < 93)
				now_ms = now_ms + $urandom_range(3000, span);
			else if (r < 97)
				now_ms = $urandom();
			else
				now_ms = 32'hFFFF_FFFF - $urandom_range(0, span);
			if ($urandom_range(0, 9) < 6)
				pin_now = ~pin_now;
			add_tick(now_ms, pin_now);
		end
	endtask

	// sender holds off until every tick is taken and every beat is back
	task automatic wait_drained();
		while (ticks_taken != ticks_issued || reports_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_ENABLED: begin
				cfg_en = data[0];
				in_backoff = 1'b0;
				end_wrapped = 1'b0;
				armed = 1'b0;
			end
			CFG_RISING_EDGE:     cfg_rise = data[0];
			CFG_BACKOFF_SECONDS: cfg_secs = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// tick driver
	always @(posedge clk or negedge arst_n) begin : tick_drv
		tick_item_t nxt;
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
			tick_ch.time_ms <= '0;
			tick_ch.pin_level <= 1'b0;
		end else begin
			if (tick_ch.valid && tick_ch.ready) begin
				compute_reports(tick_ch.time_ms, tick_ch.pin_level);
				ticks_taken++;
			end
			if (!tick_ch.valid || tick_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					tick_ch.valid <= 1'b0;
				end else if (ticks_pending.size() > 0) begin
					nxt = ticks_pending.pop_front();
					tick_ch.valid <= 1'b1;
					tick_ch.time_ms <= nxt.stamp;
					tick_ch.pin_level <= nxt.pin;
					if (!calm && $urandom_range(0, 4) == 0)
						gap_left = $urandom_range(1, 3);
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end
		end
	end

	// report monitor and sink stalls
	always @(posedge clk or negedge arst_n) begin : rep_mon
		report_beat_t want;
		if (!arst_n) begin
			rep_ch.ready <= 1'b0;
		end else begin
			if (rep_ch.valid && rep_ch.ready) begin
				if (reports_due.size() == 0) begin
					$error("report beat with nothing expected");
					errors++;
				end else begin
					want = reports_due.pop_front();
					check_field("report_type", TIME_W'(want.kind),
						TIME_W'(rep_ch.report_type));
					check_field("push_request", TIME_W'(want.push),
						TIME_W'(rep_ch.push_request));
					check_field("led_state", TIME_W'(want.led), TIME_W'(rep_ch.led_state));
					check_field("backoff_ended", TIME_W'(want.ended),
						TIME_W'(rep_ch.backoff_ended));
					check_field("suppressed_count", TIME_W'(want.supp),
						TIME_W'(rep_ch.suppressed_count));
					check_field("overrun_total", TIME_W'(want.ovr),
						TIME_W'(rep_ch.overrun_total));
					check_field("log_time", want.stamp, rep_ch.log_time);
					check_field("last", TIME_W'(want.last), TIME_W'(rep_ch.last));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rep_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 2);
				rep_ch.ready <= 1'b0;
			end else begin
				rep_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENABLED;
		cfg_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.time_ms = '0;
		tick_ch.pin_level = 1'b0;
		rep_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// disabled after reset: pin activity is ignored
		add_tick(32'd100, 1'b1);
		add_tick(32'd200, 1'b0);
		add_tick(32'd300, 1'b1);
		wait_drained();

		// enable with junk upper bits, seconds below the minimum
		write_reg(CFG_ENABLED, 16'hA5A5);
		write_reg(CFG_BACKOFF_SECONDS, 16'd0);
		write_reg(CFG_SPARE, 16'hFFFF);
		add_tick(32'd0, 1'b0);            // priming sample
		add_tick(32'd0, 1'b1);            // opens the window
		add_tick(32'd500, 1'b0);
		add_tick(32'd1200, 1'b1);         // counted as suppressed
		add_tick(32'd1300, 1'b0);
		add_tick(32'd1400, 1'b1);         // too close to the previous edge
		add_tick(32'd30000, 1'b0);        // window closes, two stamps drained
		add_tick(32'hFFFF_F000, 1'b1);    // window end wraps past 2^32
		add_tick(32'hFFFF_FFFF, 1'b0);
		add_tick(32'd16, 1'b1);           // not counted, wrap flag clears
		add_tick(32'd26000, 1'b0);        // wrapped window closes
		wait_drained();

		// longest window, falling edges; end time is cleared on a clock wrap
		write_reg(CFG_BACKOFF_SECONDS, 16'hFFFF);
		write_reg(CFG_RISING_EDGE, 16'h0000);
		add_tick(32'h8000_0000, 1'b1);
		add_tick(32'h8000_0001, 1'b0);
		add_tick(32'd100, 1'b0);
		wait_drained();

		// random: default window, rising edges
		write_reg(CFG_ENABLED, 16'h0001);
		write_reg(CFG_RISING_EDGE, 16'h0001);
		write_reg(CFG_BACKOFF_SECONDS, 16'd30);
		add_random_ticks(110, 40000);
		wait_drained();

		// falling edges, clamped seconds
		write_reg(CFG_RISING_EDGE, 16'hFFFE);
		write_reg(CFG_BACKOFF_SECONDS, 16'd29);
		add_random_ticks(90, 40000);
		wait_drained();

		// re-enable with the log still holding stamps, longest window
		write_reg(CFG_ENABLED, 16'h0001);
		write_reg(CFG_BACKOFF_SECONDS, 16'hFFFF);
		add_random_ticks(50, 70000000);
		wait_drained();

		// disabled
		write_reg(CFG_ENABLED, 16'hFFFE);
		add_random_ticks(20, 40000);
		wait_drained();

		// last stretch without any idling on either side
		write_reg(CFG_ENABLED, 16'($urandom()) | 16'h0001);
		write_reg(CFG_RISING_EDGE, 16'($urandom()));
		write_reg(CFG_BACKOFF_SECONDS, 16'($urandom_range(31, 200)));
		calm = 1'b1;
		add_random_ticks(130, 250000);
		wait_drained();

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/enbl_pkg.sv
rtl/core/enbl_stream_if.sv
rtl/core/edge_notify_backoff_logger.sv
verif/tb_top.sv
